// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define EPSO_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define EPSO_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define EPSO_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define EPSO_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== design/epso_pkg.sv =====
// ---------------------------------------------------------------------------
// epso_pkg
// Types, constants and the 2^x table of the pitch pulse/slope oscillator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package epso_pkg;

    localparam int PHASE_BITS   = 32;
    localparam int EXP_ENTRIES  = 256;
    localparam int EXP_IDX_BITS = 8;
    localparam int FRAC_BITS    = 11;   // 2048 units per volt (octave)
    localparam int OCT_BIAS     = 38;   // 30 + 8 octaves below center

    localparam int DIV_N_BITS   = 32;
    localparam int DIV_D_BITS   = 17;
    localparam int DIV_Q_BITS   = 20;
    localparam int DIV_CNT_BITS = 5;

    localparam logic [30:0] C4_RESET     = 31'd23409863;
    localparam logic [15:0] Q16_HALF     = 16'd32768;
    localparam logic [PHASE_BITS-1:0] HALF_CYCLE = {1'b1, {(PHASE_BITS-1){1'b0}}};
    localparam logic signed [14:0] OUT_HIGH = 15'sd10240;
    localparam logic signed [14:0] OUT_LOW  = -15'sd10240;
    localparam logic [14:0] OUT_SWING   = 15'd10240;
    localparam logic [14:0] SLOPE_SPAN  = 15'd20480;
    localparam logic [16:0] CYCLE_Q16   = 17'd65536;
    // x/5 = (x * RECIP5) >> 22, exact for x below 2^22
    localparam logic [19:0] RECIP5        = 20'd838861;
    localparam int          RECIP5_SHIFT  = 22;
    // x/25 = (x * RECIP25) >> 26, exact for x below 6.1e6
    localparam logic [21:0] RECIP25       = 22'd2684355;
    localparam int          RECIP25_SHIFT = 26;
    localparam int PW_SHIFT = 13;
    localparam int FM_SHIFT = 14;

    typedef logic [31:0] exp_entry_t;
    typedef exp_entry_t exp_tab_t [0:EXP_ENTRIES];

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        rem = x;
        r   = '0;
        b   = 64'd1 << 62;
        for (int j = 0; j < 32; j++)
        begin
            if (rem >= r + b)
            begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Q2.30 values of 2^(i/EXP_ENTRIES) from chained square roots of two
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t    t;
        logic [63:0] roots [0:15];
        logic [63:0] v;
        logic [63:0] x;
        roots[0] = isqrt64(64'd1 << 61);
        for (int k = 1; k < 16; k++)
        begin
            roots[k] = isqrt64(roots[k-1] << 30);
        end
        for (int i = 0; i < EXP_ENTRIES; i++)
        begin
            x = (64'(i) << 16) / EXP_ENTRIES;
            v = 64'd1 << 30;
            for (int k = 0; k < 16; k++)
            begin
                if (x[15-k])
                begin
                    v = (v * roots[k]) >> 30;
                end
            end
            t[i] = v[31:0];
        end
        t[EXP_ENTRIES] = 32'h8000_0000;
        return t;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

    typedef enum logic [2:0] {
        CFG_PITCH_OFFSET    = 3'd0,
        CFG_FM_GAIN         = 3'd1,
        CFG_FOLLOW_MODE     = 3'd2,
        CFG_DURATION_OFFSET = 3'd3,
        CFG_RATIO_BASE      = 3'd4,
        CFG_WIDTH_BASE      = 3'd5,
        CFG_C4_INCREMENT    = 3'd6
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_LOAD  = 4'd1,
        OP_MUL   = 4'd2,
        OP_PITCH = 4'd3,
        OP_EXP   = 4'd4,
        OP_MANT  = 4'd5,
        OP_CMUL  = 4'd6,
        OP_PHASE = 4'd7,
        OP_DGO   = 4'd8,
        OP_DUSE  = 4'd9,
        OP_OUT   = 4'd10
    } op_t;

    typedef enum logic {
        DS_SPITCH = 1'b0,
        DS_SLOPE  = 1'b1
    } div_sel_t;

    typedef struct packed {
        op_t      op;
        logic     osc;    // 0: main oscillator, 1: slope oscillator
        div_sel_t dsel;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

// ===== design/epso_div.sv =====
// ---------------------------------------------------------------------------
// epso_div
// Shared restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module epso_div
    import epso_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIV_N_BITS-1:0] dividend,
    input  logic [DIV_D_BITS-1:0] divisor,
    output logic [DIV_Q_BITS-1:0] quotient,
    output logic                  done
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DIV_D_BITS-1:0]   rem_reg, rem_next;
    logic [DIV_Q_BITS-1:0]   q_reg, q_next;
    logic [DIV_D_BITS-1:0]   den_reg, den_next;
    logic [DIV_D_BITS:0]     trial;
    logic [DIV_D_BITS:0]     diff;
    logic                    ge;

    assign trial = {rem_reg, q_reg[DIV_Q_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    // caller guarantees the quotient fits in DIV_Q_BITS
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_BITS'(DIV_Q_BITS);
            rem_next  = DIV_D_BITS'(dividend[DIV_N_BITS-1:DIV_Q_BITS]);
            q_next    = dividend[DIV_Q_BITS-1:0];
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIV_D_BITS-1:0] : trial[DIV_D_BITS-1:0];
            q_next   = {q_reg[DIV_Q_BITS-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign quotient = q_reg;
    assign done     = done_reg;

    `EPSO_ASSERT_IMP(a_done_idle, clk, rst_n, done_reg, !busy_reg)
    `EPSO_ASSERT_NXT(a_start_busy, clk, rst_n, start, busy_reg && cnt_reg == DIV_CNT_BITS'(DIV_Q_BITS))

endmodule

// ===== design/epso_dp.sv =====
// ---------------------------------------------------------------------------
// epso_dp
// Datapath: registers, pitch math, 2^x increment unit, phases and outputs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module epso_dp
    import epso_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic signed [15:0] pitch_cv,
    input  logic signed [15:0] fm_cv,
    input  logic signed [15:0] duration_cv,
    input  logic signed [15:0] ratio_cv,
    input  logic signed [15:0] width_cv,
    input  logic               width_connected,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [14:0] pulse_out,
    output logic signed [14:0] slope_out
);

    // configuration
    logic signed [14:0] pitch_offset_reg;
    logic signed [15:0] fm_gain_reg;
    logic               follow_reg;
    logic signed [14:0] dur_offset_reg;
    logic [15:0]        ratio_base_reg;
    logic [15:0]        width_base_reg;
    logic [30:0]        c4_reg;

    // item inputs
    logic signed [15:0] pcv_reg, fcv_reg, dcv_reg, rcv_reg, wcv_reg;
    logic               wcon_reg;

    logic signed [31:0] fmprod_reg;
    logic signed [33:0] wp_reg;
    logic signed [16:0] dur_reg;
    logic signed [15:0] pitch_reg;
    logic [3:0]         divn_reg;
    logic signed [15:0] spitch_reg;
    logic [15:0]        ratio_reg;
    logic [21:0]        pwy_reg;
    logic signed [21:0] pw_reg;
    logic [14:0]        slope_q_reg;

    logic [31:0]        base_reg;
    logic [41:0]        dprod_reg;
    logic [4:0]         oct_reg;
    logic [31:0]        mant_reg;
    logic [62:0]        full_reg;

    logic [PHASE_BITS-1:0] main_phase_reg, slope_phase_reg;

    logic               out_valid_reg;
    logic signed [14:0] pulse_reg, slope_reg;

    // ---- configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_offset_reg <= '0;
            fm_gain_reg      <= '0;
            follow_reg       <= 1'b0;
            dur_offset_reg   <= '0;
            ratio_base_reg   <= Q16_HALF;
            width_base_reg   <= Q16_HALF;
            c4_reg           <= C4_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PITCH_OFFSET:    pitch_offset_reg <= cfg_data[14:0];
                CFG_FM_GAIN:         fm_gain_reg      <= cfg_data[15:0];
                CFG_FOLLOW_MODE:     follow_reg       <= cfg_data[0];
                CFG_DURATION_OFFSET: dur_offset_reg   <= cfg_data[14:0];
                CFG_RATIO_BASE:      ratio_base_reg   <= cfg_data[15:0];
                CFG_WIDTH_BASE:      width_base_reg   <= cfg_data[15:0];
                CFG_C4_INCREMENT:    c4_reg           <= cfg_data;
                default:             ;
            endcase
        end
    end

    // ---- products and sums
    logic signed [16:0] wcv_bias;
    logic signed [16:0] wb_s;
    logic signed [33:0] wp_next;
    logic signed [31:0] fm_next;
    logic signed [16:0] dur_next;

    assign wcv_bias = {wcv_reg[15], wcv_reg} + 17'sd2048;
    assign wb_s     = {1'b0, width_base_reg};
    assign wp_next  = wb_s * wcv_bias;
    assign fm_next  = fcv_reg * fm_gain_reg;
    assign dur_next = {{2{dur_offset_reg[14]}}, dur_offset_reg} + {dcv_reg[15], dcv_reg};

    // ---- pitch and follow divisor
    logic signed [31:0] fm_adj;
    logic signed [17:0] fm_q;
    logic signed [19:0] psum;
    logic signed [15:0] pitch_next;
    logic signed [16:0] dur_adj;
    logic signed [6:0]  dq;
    logic signed [6:0]  dn;
    logic [3:0]         divn_next;

    assign fm_adj = fmprod_reg + (fmprod_reg[31] ? 32'sd16383 : 32'sd0);
    assign fm_q   = 18'(fm_adj >>> FM_SHIFT);
    assign psum   = 20'(pitch_offset_reg) + 20'(pcv_reg) + 20'(fm_q);
    assign pitch_next = (psum > 20'sd16384)  ? 16'sd16384 :
                        (psum < -20'sd16384) ? -16'sd16384 : psum[15:0];

    assign dur_adj = dur_reg + (dur_reg[16] ? 17'sd2047 : 17'sd0);
    assign dq      = 7'(dur_adj >>> FRAC_BITS);
    assign dn      = dq + 7'sd5;
    assign divn_next = (dn < 7'sd1) ? 4'd1 : (dn > 7'sd15) ? 4'd15 : dn[3:0];

    // ---- ratio and pulse width, constant divisions by reciprocal
    logic [19:0]        r16_mag;
    logic [41:0]        r_prod;
    logic [19:0]        r_quo;
    logic signed [20:0] rq;
    logic signed [21:0] rsum;
    logic [15:0]        ratio_next;
    logic signed [37:0] wp9;
    logic [37:0]        wp9_mag;
    logic [21:0]        pwy_next;
    logic [47:0]        pw_prod;
    logic [21:0]        pw_quo;
    logic signed [21:0] pw_div;
    logic signed [21:0] pw_next;

    assign r16_mag = rcv_reg[15] ? 20'(-{rcv_reg, 4'b0}) : 20'({rcv_reg, 4'b0});
    assign r_prod  = 42'(r16_mag) * 42'(RECIP5);
    assign r_quo   = 20'(r_prod >> RECIP5_SHIFT);
    assign rq      = rcv_reg[15] ? -21'(r_quo) : 21'(r_quo);
    assign rsum    = $signed({6'b0, ratio_base_reg}) + 22'(rq);
    assign ratio_next = (rsum < 22'sd1) ? 16'd1 :
                        (rsum > 22'sd65535) ? 16'd65535 : rsum[15:0];

    // |wp*9| / 204800 = (|wp*9| >> 13) / 25
    assign wp9      = (38'(wp_reg) <<< 3) + 38'(wp_reg);
    assign wp9_mag  = wp9[37] ? 38'(-wp9) : 38'(wp9);
    assign pwy_next = 22'(wp9_mag >> PW_SHIFT);
    assign pw_prod  = 48'(pwy_reg) * 48'(RECIP25);
    assign pw_quo   = 22'(pw_prod >> RECIP25_SHIFT);
    assign pw_div   = wp_reg[33] ? -$signed(pw_quo) : $signed(pw_quo);
    assign pw_next  = wcon_reg ? pw_div : $signed({6'b0, width_base_reg});

    // ---- 2^x increment unit
    logic signed [15:0]    p_sel;
    logic [15:0]           u;
    logic [FRAC_BITS-1:0]  frac;
    logic [EXP_IDX_BITS-1:0] idx;
    logic [EXP_IDX_BITS:0] idx_hi;
    logic [FRAC_BITS-1:0]  rem;
    logic [31:0]           tab_lo, tab_hi;
    logic [5:0]            shamt;
    logic [62:0]           inc_wide;
    logic [PHASE_BITS-1:0] inc;

    assign p_sel  = cmd.osc ? spitch_reg : pitch_reg;
    assign u      = 16'(p_sel + 16'sd16384);
    assign frac   = u[FRAC_BITS-1:0];
    assign idx    = frac[FRAC_BITS-1 -: EXP_IDX_BITS];
    assign idx_hi = {1'b0, idx} + 1'b1;
    assign rem    = FRAC_BITS'(frac[FRAC_BITS-EXP_IDX_BITS-1:0]) << EXP_IDX_BITS;
    assign tab_lo = EXP_TAB[idx];
    assign tab_hi = EXP_TAB[idx_hi];

    assign shamt    = 6'(OCT_BIAS) - {1'b0, oct_reg};
    assign inc_wide = full_reg >> shamt;
    assign inc      = (inc_wide > 63'(HALF_CYCLE)) ? HALF_CYCLE : inc_wide[PHASE_BITS-1:0];

    // ---- divider operands
    logic [15:0] pitch_mag;
    logic [15:0] s_q16;
    logic        rising;
    logic [16:0] fall_span;
    logic [16:0] fall_den;
    logic [31:0] slope_num;
    logic [31:0] div_n;
    logic [16:0] div_d;
    logic [DIV_Q_BITS-1:0] div_q;
    logic        div_done;

    assign pitch_mag = pitch_reg[15] ? 16'(-pitch_reg) : 16'(pitch_reg);
    assign s_q16     = slope_phase_reg[PHASE_BITS-1 -: 16];
    assign rising    = s_q16 < ratio_reg;
    assign fall_span = CYCLE_Q16 - {1'b0, s_q16};
    assign fall_den  = CYCLE_Q16 - {1'b0, ratio_reg};
    assign slope_num = rising ? 32'({1'b0, s_q16}) * 32'(SLOPE_SPAN)
                              : 32'(fall_span) * 32'(SLOPE_SPAN);

    always_comb
    begin
        case (cmd.dsel)
            DS_SPITCH:
            begin
                div_n = 32'(pitch_mag);
                div_d = 17'(divn_reg);
            end
            default:
            begin
                div_n = slope_num;
                div_d = rising ? {1'b0, ratio_reg} : fall_den;
            end
        endcase
    end

    epso_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == OP_DGO),
        .dividend (div_n),
        .divisor  (div_d),
        .quotient (div_q),
        .done     (div_done)
    );

    // ---- results of divisions
    logic signed [15:0] sp_follow, sp_clamp;

    assign sp_follow = pitch_reg[15] ? -16'(div_q) : 16'(div_q);
    assign sp_clamp  = (dur_reg > 17'sd16384)  ? 16'sd16384 :
                       (dur_reg < -17'sd16384) ? -16'sd16384 : dur_reg[15:0];

    // ---- datapath registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                pcv_reg  <= pitch_cv;
                fcv_reg  <= fm_cv;
                dcv_reg  <= duration_cv;
                rcv_reg  <= ratio_cv;
                wcv_reg  <= width_cv;
                wcon_reg <= width_connected;
            end
            OP_MUL:
            begin
                fmprod_reg <= fm_next;
                wp_reg     <= wp_next;
                dur_reg    <= dur_next;
            end
            OP_PITCH:
            begin
                pitch_reg <= pitch_next;
                divn_reg  <= divn_next;
                ratio_reg <= ratio_next;
                pwy_reg   <= pwy_next;
            end
            OP_EXP:
            begin
                base_reg  <= tab_lo;
                dprod_reg <= 42'(tab_hi - tab_lo) * 42'(rem);
                oct_reg   <= u[15:FRAC_BITS];
                pw_reg    <= pw_next;   // same value on both passes
            end
            OP_MANT:
            begin
                mant_reg <= base_reg + 32'(dprod_reg >> FRAC_BITS);
            end
            OP_CMUL:
            begin
                full_reg <= 63'(c4_reg) * 63'(mant_reg);
            end
            OP_DUSE:
            begin
                case (cmd.dsel)
                    DS_SPITCH: spitch_reg  <= follow_reg ? sp_follow : sp_clamp;
                    default:   slope_q_reg <= div_q[14:0];
                endcase
            end
            OP_OUT:
            begin
                pulse_reg <= ($signed({6'b0, main_phase_reg[PHASE_BITS-1 -: 16]}) < pw_reg)
                             ? OUT_HIGH : OUT_LOW;
                slope_reg <= $signed(slope_q_reg - OUT_SWING);
            end
            default: ;
        endcase
    end

    // ---- phases and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_phase_reg  <= '0;
            slope_phase_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_PHASE)
            begin
                if (cmd.osc)
                begin
                    slope_phase_reg <= slope_phase_reg + inc;
                end
                else
                begin
                    main_phase_reg <= main_phase_reg + inc;
                end
            end
            if (cmd.op == OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign pulse_out = pulse_reg;
    assign slope_out = slope_reg;

    `EPSO_ASSERT_NXT(a_phase_hold, clk, rst_n, cmd.op != OP_PHASE, $stable(main_phase_reg) && $stable(slope_phase_reg))
    `EPSO_ASSERT_NXT(a_ratio_nonzero, clk, rst_n, cmd.op == OP_PITCH, ratio_reg != '0)
    `EPSO_ASSERT_IMP(a_pulse_level, clk, rst_n, out_valid_reg, pulse_reg == OUT_HIGH || pulse_reg == OUT_LOW)

endmodule

// ===== design/epso_ctrl.sv =====
// ---------------------------------------------------------------------------
// epso_ctrl
// Sequencer: steps the datapath through one tick's work.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module epso_ctrl
    import epso_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output cmd_t cmd,
    input  sts_t sts
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_MUL   = 11'b000_0000_0010,
        ST_PITCH = 11'b000_0000_0100,
        ST_EXP   = 11'b000_0000_1000,
        ST_MANT  = 11'b000_0001_0000,
        ST_CMUL  = 11'b000_0010_0000,
        ST_PHASE = 11'b000_0100_0000,
        ST_DGO   = 11'b000_1000_0000,
        ST_DWAIT = 11'b001_0000_0000,
        ST_DUSE  = 11'b010_0000_0000,
        ST_OUT   = 11'b100_0000_0000
    } state_t;

    state_t   state_reg, state_next;
    logic     osc_reg, osc_next;
    div_sel_t dsel_reg, dsel_next;
    op_t      op;

    always_comb
    begin
        state_next = state_reg;
        osc_next   = osc_reg;
        dsel_next  = dsel_reg;
        op         = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                osc_next = 1'b0;
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                op         = OP_MUL;
                state_next = ST_PITCH;
            end
            ST_PITCH:
            begin
                op         = OP_PITCH;
                state_next = ST_EXP;
            end
            ST_EXP:
            begin
                op         = OP_EXP;
                state_next = ST_MANT;
            end
            ST_MANT:
            begin
                op         = OP_MANT;
                state_next = ST_CMUL;
            end
            ST_CMUL:
            begin
                op         = OP_CMUL;
                state_next = ST_PHASE;
            end
            ST_PHASE:
            begin
                op         = OP_PHASE;
                dsel_next  = osc_reg ? DS_SLOPE : DS_SPITCH;
                state_next = ST_DGO;
            end
            ST_DGO:
            begin
                op         = OP_DGO;
                state_next = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_DUSE;
                end
            end
            ST_DUSE:
            begin
                op = OP_DUSE;
                case (dsel_reg)
                    DS_SPITCH:
                    begin
                        osc_next   = 1'b1;
                        state_next = ST_EXP;
                    end
                    default:
                    begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    op         = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            osc_reg   <= 1'b0;
            dsel_reg  <= DS_SPITCH;
        end
        else
        begin
            state_reg <= state_next;
            osc_reg   <= osc_next;
            dsel_reg  <= dsel_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign cmd.op   = op;
    assign cmd.osc  = osc_reg;
    assign cmd.dsel = dsel_reg;

endmodule

// ===== design/exp_pitch_pulse_and_slope_oscillator.sv =====
// ---------------------------------------------------------------------------
// exp_pitch_pulse_and_slope_oscillator
// Exponential-pitch pulse oscillator with a variable-slope ramp oscillator.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one item per audio sample tick with
//   the control voltages. in_stall is low only while the block is idle.
//   Output channel (out_valid/out_stall): one item per input item with the
//   pulse and slope voltages, held in an output register.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//   write only while no item is in flight.
// Sequence:
//   The next item is taken only after the result is in the output register,
//   so one item is worked on at a time. The work is two passes through the
//   shared 20-bit divider (slope pitch, used in follow mode, then slope
//   value), two 2^x increment passes (lookup, mantissa, C4 multiply, phase
//   add) and the load, sum and output steps.
// Reset:
//   Both phases clear, registers take their defaults, output goes empty.
// Stall:
//   A stalled result holds; the next item may be accepted and worked on,
//   its result waits until the output register frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module exp_pitch_pulse_and_slope_oscillator
    import epso_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] pitch_cv,
    input  logic signed [15:0] fm_cv,
    input  logic signed [15:0] duration_cv,
    input  logic signed [15:0] ratio_cv,
    input  logic signed [15:0] width_cv,
    input  logic               width_connected,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [14:0] pulse_out,
    output logic signed [14:0] slope_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    epso_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    epso_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .pitch_cv        (pitch_cv),
        .fm_cv           (fm_cv),
        .duration_cv     (duration_cv),
        .ratio_cv        (ratio_cv),
        .width_cv        (width_cv),
        .width_connected (width_connected),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pulse_out       (pulse_out),
        .slope_out       (slope_out)
    );

endmodule

// ===== tb/tb_exp_pitch_pulse_and_slope_oscillator.sv =====
// ---------------------------------------------------------------------------
// tb_exp_pitch_pulse_and_slope_oscillator
// Self-checking bench: each accepted sample tick is run through a bit-exact
// model of both phase accumulators, the 2^x pitch table, the pulse comparator
// and the slope ramp. Results are checked in order. The run steps through
// several register settings, the range limits among them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_exp_pitch_pulse_and_slope_oscillator;
    import epso_pkg::*;

class osc_scoreboard;
    longint          pitch_ofs, fm_mult, dur_ofs;
    longint unsigned follow, ratio_knob, width_knob, c4_step;
    longint unsigned main_acc, slope_acc;
    longint unsigned exp2_tab [0:256];
    logic signed [14:0] pulse_q [$];
    logic signed [14:0] slope_q [$];
    int errors;
    int checked;

    function new();
        longint unsigned roots [0:15];
        longint unsigned x, v;
        roots[0] = sqrt_floor(64'd1 << 61);
        for (int k = 1; k < 16; k++)
        begin
            roots[k] = sqrt_floor(roots[k-1] << 30);
        end
        for (int i = 0; i < 256; i++)
        begin
            x = (longint'(i) << 16) / 256;
            v = 64'd1 << 30;
            for (int k = 0; k < 16; k++)
            begin
                if ((x >> (15 - k)) & 1)
                begin
                    v = (v * roots[k]) >> 30;
                end
            end
            exp2_tab[i] = v;
        end
        exp2_tab[256] = 64'd1 << 31;
        pitch_ofs  = 0;
        fm_mult    = 0;
        follow     = 0;
        dur_ofs    = 0;
        ratio_knob = 32768;
        width_knob = 32768;
        c4_step    = 23409863;
        main_acc   = 0;
        slope_acc  = 0;
        errors     = 0;
        checked    = 0;
    endfunction

    function longint unsigned sqrt_floor(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void set_reg(cfg_idx_t idx, logic [30:0] d);
        case (idx)
            CFG_PITCH_OFFSET:    pitch_ofs  = longint'($signed(d[14:0]));
            CFG_FM_GAIN:         fm_mult    = longint'($signed(d[15:0]));
            CFG_FOLLOW_MODE:     follow     = d[0];
            CFG_DURATION_OFFSET: dur_ofs    = longint'($signed(d[14:0]));
            CFG_RATIO_BASE:      ratio_knob = d[15:0];
            CFG_WIDTH_BASE:      width_knob = d[15:0];
            CFG_C4_INCREMENT:    c4_step    = d;
            default: ;
        endcase
    endfunction

    // pitch in -16384..16384 -> Q0.32 step, capped at half a cycle
    function longint unsigned pitch_step(longint pitch);
        longint unsigned u, pp, idx, rem, mant, inc;
        longint oct;
        u    = longint'(pitch + 16384);
        oct  = longint'(u >> 11) - 8;
        pp   = (u & 2047) * 256;
        idx  = pp >> 11;
        rem  = pp & 2047;
        mant = exp2_tab[idx] + (((exp2_tab[idx+1] - exp2_tab[idx]) * rem) >> 11);
        inc  = (c4_step * mant) >> (30 - oct);
        return (inc > (64'd1 << 31)) ? (64'd1 << 31) : inc;
    endfunction

    function void note_input(logic signed [15:0] pc, logic signed [15:0] fc,
                             logic signed [15:0] dc, logic signed [15:0] rc,
                             logic signed [15:0] wc, logic wcon);
        longint pitch, dur, spitch, divisor, ratio, pw, slope, pulse;
        longint unsigned s;
        pitch    = pitch_ofs + longint'(pc) + (longint'(fc) * fm_mult) / 16384;
        pitch    = clamp(pitch, -16384, 16384);
        main_acc = (main_acc + pitch_step(pitch)) & 64'hFFFF_FFFF;
        dur = dur_ofs + longint'(dc);
        if (follow != 0)
        begin
            divisor = clamp(dur / 2048 + 5, 1, 15);
            spitch  = pitch / divisor;
        end
        else
        begin
            spitch = clamp(dur, -16384, 16384);
        end
        slope_acc = (slope_acc + pitch_step(spitch)) & 64'hFFFF_FFFF;
        ratio = clamp(longint'(ratio_knob) + (longint'(rc) * 16) / 5, 1, 65535);
        s = slope_acc >> 16;
        if (longint'(s) < ratio)
            slope = longint'((64'd20480 * s) / longint'(ratio)) - 10240;
        else
            slope = longint'((64'd20480 * (64'd65536 - s)) / longint'(65536 - ratio))
                    - 10240;
        pw = longint'(width_knob);
        if (wcon)
            pw = (pw * (longint'(wc) + 2048) * 9) / 204800;
        pulse = (longint'(main_acc >> 16) < pw) ? 10240 : -10240;
        pulse_q.push_back(15'(pulse));
        slope_q.push_back(15'(slope));
    endfunction

    function void check_result(logic signed [14:0] p, logic signed [14:0] s);
        logic signed [14:0] ep, es;
        if (pulse_q.size() == 0)
        begin
            $error("result with no item pending: pulse_out %0d slope_out %0d", p, s);
            errors++;
            return;
        end
        ep = pulse_q.pop_front();
        es = slope_q.pop_front();
        checked++;
        if (p !== ep)
        begin
            $error("pulse_out: expected %0d, got %0d", ep, p);
            errors++;
        end
        if (s !== es)
        begin
            $error("slope_out: expected %0d, got %0d", es, s);
            errors++;
        end
    endfunction

    function int pending();
        return pulse_q.size();
    endfunction
endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] pitch_cv = '0;
    logic signed [15:0] fm_cv = '0;
    logic signed [15:0] duration_cv = '0;
    logic signed [15:0] ratio_cv = '0;
    logic signed [15:0] width_cv = '0;
    logic               width_connected = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [14:0] pulse_out;
    logic signed [14:0] slope_out;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [30:0]        cfg_data = '0;

    osc_scoreboard sb = new();
    bit quiet = 1'b0;
    int items_sent = 0;
    int idle_cycles = 0;
    bit in_take, out_take, cfg_take;
    logic signed [14:0] pulse_seen, slope_seen;

    exp_pitch_pulse_and_slope_oscillator dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // handshakes are sampled mid-cycle and take effect at the next rising edge
    always @(negedge clk)
    begin
        in_take    = in_valid && !in_stall;
        out_take   = out_valid && !out_stall;
        cfg_take   = cfg_valid && cfg_ready;
        pulse_seen = pulse_out;
        slope_seen = slope_out;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_take)
            sb.check_result(pulse_seen, slope_seen);
        if (!rst_n || in_take || out_take || cfg_take)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int n;
        @(posedge clk);
        forever
        begin
            if (quiet)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                n = $urandom_range(1, 12);
                out_stall <= ($urandom_range(0, 2) == 0);
                if ($urandom_range(0, 9) == 0)
                    n = 300;    // long run with the stall setting held
                repeat (n) @(posedge clk);
            end
        end
    end

    task automatic cfg_write(cfg_idx_t idx, logic [30:0] d);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, d);
    endtask

    task automatic set_regs(int po, int fg, int fo, int dof, int rb, int wb, int c4);
        cfg_write(CFG_PITCH_OFFSET, 31'(po) & 31'h7FFF);
        cfg_write(CFG_FM_GAIN, 31'(fg) & 31'hFFFF);
        cfg_write(CFG_FOLLOW_MODE, 31'(fo));
        cfg_write(CFG_DURATION_OFFSET, 31'(dof) & 31'h7FFF);
        cfg_write(CFG_RATIO_BASE, 31'(rb));
        cfg_write(CFG_WIDTH_BASE, 31'(wb));
        cfg_write(CFG_C4_INCREMENT, 31'(c4));
        @(posedge clk);
    endtask

    // called at a rising edge; returns at the edge that took the item, or after a random idle gap behind it
    task automatic send_tick(logic signed [15:0] pc, logic signed [15:0] fc,
                             logic signed [15:0] dc, logic signed [15:0] rc,
                             logic signed [15:0] wc, logic wcon);
        in_valid        <= 1'b1;
        pitch_cv        <= pc;
        fm_cv           <= fc;
        duration_cv     <= dc;
        ratio_cv        <= rc;
        width_cv        <= wc;
        width_connected <= wcon;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
        sb.note_input(pc, fc, dc, rc, wc, wcon);
        items_sent++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    function automatic logic [15:0] rand_cv();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2, 3: return 16'($urandom_range(0, 8192) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_ticks(int n);
        for (int i = 0; i < n; i++)
            send_tick(rand_cv(), rand_cv(), rand_cv(), rand_cv(), rand_cv(),
                      $urandom_range(0, 1));
    endtask

    // idle point: everything delivered, then a margin for the pipeline
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults first, with field extremes
        send_tick(16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_tick(-16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_tick(16'sd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
        send_tick(16'sd0, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 1'b1);
        send_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd2048, 1'b1);  // zero width
        send_tick(16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd2048, 1'b1);
        send_tick(-16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 1'b0);
        send_tick(16'sd2048, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        random_ticks(100);
        drain();

        // follow mode, upper extremes
        set_regs(11264, 16384, 1, 10220, 64880, 58982, 32'h7FFF_FFFF);
        send_tick(16'sd0, 16'sd0, 16'sd20480, 16'sd0, 16'sd0, 1'b0);   // divisor cap
        send_tick(16'sd0, 16'sd0, -16'sh8000, 16'sd0, 16'sd0, 1'b0);   // divisor floor
        send_tick(-16'sh8000, 16'sh7FFF, -16'sd12288, 16'sd0, 16'sd0, 1'b1);
        random_ticks(120);
        drain();

        // follow mode, lower extremes
        set_regs(-11264, -16384, 1, -10220, 655, 6554, 1);
        random_ticks(120);
        drain();

        // normal mode, random settings
        set_regs($urandom_range(0, 22528) - 11264, $urandom_range(0, 32768) - 16384, 0,
                 $urandom_range(0, 20440) - 10220, $urandom_range(655, 64880),
                 $urandom_range(6554, 58982), $urandom_range(1000000, 200000000));
        random_ticks(120);
        drain();

        // random follow setting, no idling on either side
        set_regs($urandom_range(0, 22528) - 11264, $urandom_range(0, 32768) - 16384, 1,
                 $urandom_range(0, 20440) - 10220, $urandom_range(655, 64880),
                 $urandom_range(6554, 58982), 23409863);
        quiet = 1'b1;
        random_ticks(120);
        drain();

        $display("Covered %0d sample ticks, %0d results checked, five register settings",
                 items_sent, sb.checked);
        $display("with follow and normal slope modes, PWM patched and unpatched.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
